### sv/hhtj_pkg.sv
package hhtj_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } hhtj_op_t;

  localparam logic [7:0] OFS_JOYP = 8'h00;
  localparam logic [7:0] OFS_DIV  = 8'h04;
  localparam logic [7:0] OFS_TIMA = 8'h05;
  localparam logic [7:0] OFS_TMA  = 8'h06;
  localparam logic [7:0] OFS_TAC  = 8'h07;
  localparam logic [7:0] OFS_IF   = 8'h0F;
  localparam logic [7:0] OFS_IE   = 8'hFF;

  localparam int DIV_PERIOD_DEF = 256;
  localparam int DOT_W          = 10;

  localparam int IRQ_TIMER_BIT  = 2;
  localparam int IRQ_JOYP_BIT   = 4;
  localparam int TAC_EN_BIT     = 2;

  // write strobes from the bus decoder into the timer
  typedef struct packed {
    logic       div_clr;
    logic       tima_wr;
    logic       tma_wr;
    logic       tac_wr;
    logic [7:0] data;
  } hhtj_wr_t;

  // timer register view back to the bus side
  typedef struct packed {
    logic [7:0] div;
    logic [7:0] tima;
    logic [7:0] tma;
    logic [7:0] tac;
    logic       ovf;
  } hhtj_tmr_t;

  // dot_count mask for the TAC-selected period: 1024, 16, 64, 256 dots
  function automatic logic [DOT_W-1:0] tac_mask(input logic [1:0] sel);
    logic [DOT_W-1:0] m;
    unique case (sel)
      2'd0: m = 10'h3FF;
      2'd1: m = 10'h00F;
      2'd2: m = 10'h03F;
      2'd3: m = 10'h0FF;
      default: m = 10'h3FF;
    endcase
    return m;
  endfunction

endpackage

### sv/handheld_timer_joypad_registers.sv
// Timer, divider, interrupt-flag and joypad I/O registers. Each transaction
// is a bus read, a bus write, one dot tick or a no-op, and yields exactly one
// result: the read byte (0 for anything but a read) and the IF byte after the
// item. One transaction is taken every cycle while in_stall is low; its result
// appears in the output register on the next cycle, and in_stall rises only
// while that register holds a result that the receiver is stalling. DIV
// advances every DIV_PERIOD dots; TIMA advances at the TAC-selected period.
module handheld_timer_joypad_registers #(
  parameter int DIV_PERIOD = hhtj_pkg::DIV_PERIOD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_buttons,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [7:0] out_interrupt_flags
);
  import hhtj_pkg::*;

  logic       accept;
  logic       is_rd, is_wr, is_tick;
  hhtj_wr_t   wr;
  hhtj_tmr_t  tmr;

  logic [7:0] joyp_r, joyp_nxt;
  logic       joyp_wr_r, joyp_wr_nxt;
  logic [7:0] if_r, if_nxt;
  logic [7:0] ie_r, ie_nxt;
  logic [3:0] nib;
  logic       joyp_irq;
  logic [7:0] rd;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rd_r, out_if_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_rd    = accept && (in_opcode == OP_READ);
  assign is_wr    = accept && (in_opcode == OP_WRITE);
  assign is_tick  = accept && (in_opcode == OP_TICK);

  always_comb begin
    wr.div_clr = is_wr && (in_reg_offset == OFS_DIV);
    wr.tima_wr = is_wr && (in_reg_offset == OFS_TIMA);
    wr.tma_wr  = is_wr && (in_reg_offset == OFS_TMA);
    wr.tac_wr  = is_wr && (in_reg_offset == OFS_TAC);
    wr.data    = in_write_data;
  end

  hhtj_timer #(
    .DIV_PERIOD(DIV_PERIOD)
  ) u_timer (
    .clk  (clk),
    .rst_n(rst_n),
    .tick (is_tick),
    .wr   (wr),
    .tmr  (tmr)
  );

  // d-pad group wins when both select bits are low
  always_comb begin
    nib = joyp_r[3:0];
    if (!joyp_r[4]) begin
      nib = ~in_buttons[7:4];
    end else if (!joyp_r[5]) begin
      nib = ~in_buttons[3:0];
    end
    joyp_irq = !joyp_wr_r && ((joyp_r[3:0] & ~nib) != 4'd0);
  end

  always_comb begin
    joyp_nxt    = joyp_r;
    joyp_wr_nxt = joyp_wr_r;
    if_nxt      = if_r;
    ie_nxt      = ie_r;
    if (is_tick) begin
      joyp_nxt    = {joyp_r[7:4], nib};
      joyp_wr_nxt = 1'b0;
      if_nxt[IRQ_JOYP_BIT]  = if_r[IRQ_JOYP_BIT] | joyp_irq;
      if_nxt[IRQ_TIMER_BIT] = if_r[IRQ_TIMER_BIT] | tmr.ovf;
    end
    if (is_wr) begin
      unique case (in_reg_offset)
        OFS_JOYP: begin
          joyp_nxt    = in_write_data;
          joyp_wr_nxt = 1'b1;
        end
        OFS_IF:  if_nxt = in_write_data;
        OFS_IE:  ie_nxt = in_write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd = 8'd0;
    if (is_rd) begin
      unique case (in_reg_offset)
        OFS_JOYP: rd = joyp_r;
        OFS_DIV:  rd = tmr.div;
        OFS_TIMA: rd = tmr.tima;
        OFS_TMA:  rd = tmr.tma;
        OFS_TAC:  rd = tmr.tac;
        OFS_IF:   rd = if_r;
        OFS_IE:   rd = ie_r;
        default:  rd = 8'd0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joyp_r      <= '0;
      joyp_wr_r   <= 1'b0;
      if_r        <= '0;
      ie_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      joyp_r      <= joyp_nxt;
      joyp_wr_r   <= joyp_wr_nxt;
      if_r        <= if_nxt;
      ie_r        <= ie_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r <= rd;
      out_if_r <= if_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_rd_r;
  assign out_interrupt_flags = out_if_r;

endmodule

### sv/hhtj_timer.sv
module hhtj_timer #(
  parameter int DIV_PERIOD = hhtj_pkg::DIV_PERIOD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  hhtj_pkg::hhtj_wr_t wr,
  output hhtj_pkg::hhtj_tmr_t tmr
);
  import hhtj_pkg::*;

  localparam int PH_W = (DIV_PERIOD > 1) ? $clog2(DIV_PERIOD) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(DIV_PERIOD - 1);

  logic [DOT_W-1:0] dot_r,  dot_nxt;
  logic [PH_W-1:0]  ph_r,   ph_nxt;
  logic [7:0]       div_r,  div_nxt;
  logic [7:0]       tima_r, tima_nxt;
  logic [7:0]       tma_r,  tma_nxt;
  logic [7:0]       tac_r,  tac_nxt;
  logic             ovf;
  logic             tima_step;

  // ph_r tracks dot_count mod DIV_PERIOD, restarting when dot_count wraps
  always_comb begin
    dot_nxt  = dot_r;
    ph_nxt   = ph_r;
    div_nxt  = div_r;
    tima_nxt = tima_r;
    tma_nxt  = tma_r;
    tac_nxt  = tac_r;
    ovf      = 1'b0;
    tima_step = tac_r[TAC_EN_BIT] && ((dot_r & tac_mask(tac_r[1:0])) == '0);
    if (tick) begin
      if (ph_r == '0) begin
        div_nxt = div_r + 8'd1;
      end
      if (tima_step) begin
        if (tima_r == 8'hFF) begin
          tima_nxt = tma_r;
          ovf      = 1'b1;
        end else begin
          tima_nxt = tima_r + 8'd1;
        end
      end
      dot_nxt = dot_r + DOT_W'(1);
      if (ph_r == PH_LAST || dot_r == '1) begin
        ph_nxt = '0;
      end else begin
        ph_nxt = ph_r + PH_W'(1);
      end
    end
    if (wr.div_clr) div_nxt  = 8'd0;
    if (wr.tima_wr) tima_nxt = wr.data;
    if (wr.tma_wr)  tma_nxt  = wr.data;
    if (wr.tac_wr)  tac_nxt  = wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      ph_r   <= '0;
      div_r  <= '0;
      tima_r <= '0;
      tma_r  <= '0;
      tac_r  <= '0;
    end else begin
      dot_r  <= dot_nxt;
      ph_r   <= ph_nxt;
      div_r  <= div_nxt;
      tima_r <= tima_nxt;
      tma_r  <= tma_nxt;
      tac_r  <= tac_nxt;
    end
  end

  always_comb begin
    tmr.div  = div_r;
    tmr.tima = tima_r;
    tmr.tma  = tma_r;
    tmr.tac  = tac_r;
    tmr.ovf  = ovf;
  end

endmodule

### sv/hhtj_checker.sv
module hhtj_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic [7:0] in_reg_offset,
  input logic [7:0] in_write_data,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic [7:0] out_interrupt_flags
);
  import hhtj_pkg::*;

  logic acc;
  assign acc = in_valid && !in_stall;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted transaction produced no result");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_opcode != OP_READ) |=> (out_read_data == 8'd0))
    else $error("non-read transaction returned data");

  a_if_write: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_opcode == OP_WRITE && in_reg_offset == OFS_IF)
      |=> (out_interrupt_flags == $past(in_write_data)))
    else $error("IF write not reflected");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_data) && $stable(out_interrupt_flags)))
    else $error("stalled result changed");

endmodule

bind handheld_timer_joypad_registers hhtj_checker u_hhtj_checker (.*);
